[rtl/pal_pkg.sv]
// ---------------------------------------------------------------------------
// pal_pkg: shared types and constants of the positional array list
// Holds the list geometry, command and status codes, and the structs that
// pass between the cells, the group reducers and the top level.
// ---------------------------------------------------------------------------
package pal_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 7;
	localparam int FPOS_W   = 6;
	localparam int LEN_W    = 7;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// Width at which positions, indexes and the length are compared.
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	// Width used to bring a cell index to the reported position width.
	localparam int FEXT_W   = (IDX_W > FPOS_W) ? IDX_W : FPOS_W;
	localparam int GROUP    = 8;
	localparam int LIDX_W   = $clog2(GROUP);
	localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;
	localparam int NCELL    = NGROUP * GROUP;

	typedef enum logic [1:0] {
		CMD_INSERT   = 2'd0,
		CMD_DELETE   = 2'd1,
		CMD_RETRIEVE = 2'd2,
		CMD_FIND     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	// Command broadcast to every cell in the cycle a beat is accepted.
	typedef struct packed {
		logic              do_ins;
		logic              do_del;
		logic [CMP_W-1:0]  pos;
		logic [CMP_W-1:0]  count;
		logic [DATA_W-1:0] value;
	} bcast_t;

	// Reduced result of one group of cells.
	typedef struct packed {
		logic              any_hit;
		logic [LIDX_W-1:0] first;
		logic [DATA_W-1:0] rdata;
	} grp_t;

endpackage

[rtl/positional_array_list_unit.sv]
// ---------------------------------------------------------------------------
// positional_array_list_unit: ordered list of signed values in a cell chain
// Every command (insert, delete, retrieve, find) gives one result beat.
// ---------------------------------------------------------------------------
//
//   channel  handshake            payload
//   -------  -------------------  -------------------------------------------
//   in       in_valid / in_stall  cmd, position, data_value
//   out      out_valid/out_stall  read_value, found_position, status,
//                                 list_length
//
// One command is accepted per cycle unless the output stalls; its result is
// registered in stage one (group reduction) and stage two (group merge).
// Inserts and deletes shift the cells at and above the position in parallel
// at acceptance, so a following command already sees the updated list.
// Reset clears the length and the pipeline valids; cell contents stay
// undefined and are never observed beyond the length.
// A stalled output freezes both stages and holds in_stall high.
module positional_array_list_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  cmd,
	input  logic [6:0]                  position,
	input  logic signed [31:0]          data_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [31:0]          read_value,
	output logic [5:0]                  found_position,
	output logic [1:0]                  status,
	output logic [6:0]                  list_length
);

	localparam int CAP    = pal_pkg::CAPACITY;
	localparam int DW     = pal_pkg::DATA_W;
	localparam int CMP_W  = pal_pkg::CMP_W;
	localparam int NCELL  = pal_pkg::NCELL;
	localparam int NGROUP = pal_pkg::NGROUP;
	localparam int GROUP  = pal_pkg::GROUP;

	// The whole pipeline advances together whenever the output is free.
	logic advance;
	logic accept;

	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;
	assign accept   = in_valid && advance;

	// Length register and the checks done at acceptance.
	logic [pal_pkg::CNT_W-1:0] count_q;
	logic [pal_pkg::CNT_W-1:0] count_next;
	logic [CMP_W-1:0]          pos_w;
	logic [CMP_W-1:0]          cnt_w;
	pal_pkg::cmd_t             op;
	pal_pkg::status_t          st_pre;
	logic                      ins_ok;
	logic                      del_ok;

	assign op    = pal_pkg::cmd_t'(cmd);
	assign pos_w = CMP_W'(position);
	assign cnt_w = CMP_W'(count_q);

	always_comb begin
		st_pre     = pal_pkg::ST_OK;
		ins_ok     = 1'b0;
		del_ok     = 1'b0;
		count_next = count_q;
		case (op)
			pal_pkg::CMD_INSERT: begin
				// The position check comes before the full check.
				if (pos_w > cnt_w) begin
					st_pre = pal_pkg::ST_RANGE;
				end else if (count_q == pal_pkg::CNT_W'(CAP)) begin
					st_pre = pal_pkg::ST_FULL;
				end else begin
					ins_ok     = 1'b1;
					count_next = count_q + 1'b1;
				end
			end
			pal_pkg::CMD_DELETE: begin
				if (pos_w >= cnt_w) begin
					st_pre = pal_pkg::ST_RANGE;
				end else begin
					del_ok     = 1'b1;
					count_next = count_q - 1'b1;
				end
			end
			pal_pkg::CMD_RETRIEVE: begin
				if (pos_w >= cnt_w) begin
					st_pre = pal_pkg::ST_RANGE;
				end
			end
			default: begin
				// A find settles its status once the hits are merged.
				st_pre = pal_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	// Broadcast to the chain of cells.
	pal_pkg::bcast_t bc;

	always_comb begin
		bc.do_ins = accept && ins_ok;
		bc.do_del = accept && del_ok;
		bc.pos    = pos_w;
		bc.count  = cnt_w;
		bc.value  = data_value;
	end

	logic [CAP-1:0][DW-1:0]   entry;
	logic [NCELL-1:0]         hit;
	logic [NCELL-1:0][DW-1:0] rdata;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		if (i < CAP) begin : g_real
			logic [DW-1:0] left_d;
			logic [DW-1:0] right_d;
			if (i == 0) begin : g_first
				assign left_d = '0;
			end else begin : g_mid_l
				assign left_d = entry[i-1];
			end
			if (i == CAP - 1) begin : g_last
				assign right_d = '0;
			end else begin : g_mid_r
				assign right_d = entry[i+1];
			end
			pal_cell u_cell (
				.clk   (clk),
				.idx   (pal_pkg::IDX_W'(i)),
				.bc    (bc),
				.left  (left_d),
				.right (right_d),
				.entry (entry[i]),
				.hit   (hit[i]),
				.rdata (rdata[i])
			);
		end else begin : g_pad
			assign hit[i]   = 1'b0;
			assign rdata[i] = '0;
		end
	end

	// Stage one: per-group reduction, registered.
	pal_pkg::grp_t [NGROUP-1:0] grp;
	pal_pkg::grp_t [NGROUP-1:0] grp_s1;
	logic                       valid_s1;
	pal_pkg::cmd_t              cmd_s1;
	pal_pkg::status_t           st_s1;
	logic [pal_pkg::CNT_W-1:0]  count_s1;

	for (genvar g = 0; g < NGROUP; g++) begin : g_grp
		pal_group u_group (
			.hit   (hit[g*GROUP +: GROUP]),
			.rdata (rdata[g*GROUP +: GROUP]),
			.res   (grp[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			grp_s1   <= grp;
			cmd_s1   <= op;
			st_s1    <= st_pre;
			count_s1 <= count_next;
		end
	end

	// Stage two: merge the groups into the output register.
	logic                      any_hit;
	logic [pal_pkg::IDX_W-1:0] first_idx;
	logic [DW-1:0]             rd_all;

	always_comb begin
		any_hit   = 1'b0;
		first_idx = '0;
		rd_all    = '0;
		for (int g = NGROUP - 1; g >= 0; g--) begin
			if (grp_s1[g].any_hit) begin
				any_hit   = 1'b1;
				first_idx = pal_pkg::IDX_W'(g * GROUP) + pal_pkg::IDX_W'(grp_s1[g].first);
			end
			rd_all = rd_all | grp_s1[g].rdata;
		end
	end

	logic                          out_valid_q;
	logic [DW-1:0]                 read_q;
	logic [pal_pkg::FEXT_W-1:0]    fpos_ext;
	logic [pal_pkg::FPOS_W-1:0]    fpos_q;
	pal_pkg::status_t              status_q;
	logic [CMP_W-1:0]              len_ext;
	logic [pal_pkg::LEN_W-1:0]     len_q;

	assign fpos_ext = pal_pkg::FEXT_W'(first_idx);
	assign len_ext  = CMP_W'(count_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			len_q <= len_ext[pal_pkg::LEN_W-1:0];
			if (cmd_s1 == pal_pkg::CMD_RETRIEVE && st_s1 == pal_pkg::ST_OK) begin
				read_q <= rd_all;
			end else begin
				read_q <= '0;
			end
			if (cmd_s1 == pal_pkg::CMD_FIND) begin
				status_q <= any_hit ? pal_pkg::ST_OK : pal_pkg::ST_MISS;
				fpos_q   <= any_hit ? fpos_ext[pal_pkg::FPOS_W-1:0] : '0;
			end else begin
				status_q <= st_s1;
				fpos_q   <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign read_value     = read_q;
	assign found_position = fpos_q;
	assign status         = status_q;
	assign list_length    = len_q;

`ifndef NO_ASSERTIONS
	// The length never grows past the number of cells.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pal_pkg::CNT_W'(CAP))
		else $error("list length exceeds capacity");

	// The length changes only when a command is accepted.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("list length changed without a command");

	// One command moves the length by at most one entry.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (count_q == $past(count_q)) ||
			(count_q == $past(count_q) + 1'b1) ||
			(count_q + 1'b1 == $past(count_q)))
		else $error("list length moved by more than one");

	// A delete on an empty list is flagged as out of range.
	a_del_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == pal_pkg::CMD_DELETE && count_q == '0) |=>
			(valid_s1 && st_s1 == pal_pkg::ST_RANGE))
		else $error("delete on empty list not flagged");

	// A nonzero found position comes only with an ok status.
	a_fpos_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found_position != '0) |-> status == pal_pkg::ST_OK)
		else $error("found position reported with a failing status");
`endif

endmodule

[rtl/pal_cell.sv]
// ---------------------------------------------------------------------------
// pal_cell: one storage cell of the list
// Holds one entry, takes from a neighbor when the list shifts, and reports
// a search hit and its masked contents for a read.
// ---------------------------------------------------------------------------
module pal_cell (
	input  logic                          clk,
	input  logic [pal_pkg::IDX_W-1:0]     idx,
	input  pal_pkg::bcast_t               bc,
	input  logic [pal_pkg::DATA_W-1:0]    left,
	input  logic [pal_pkg::DATA_W-1:0]    right,
	output logic [pal_pkg::DATA_W-1:0]    entry,
	output logic                          hit,
	output logic [pal_pkg::DATA_W-1:0]    rdata
);

	logic [pal_pkg::DATA_W-1:0] entry_q;
	logic [pal_pkg::CMP_W-1:0]  my_pos;

	assign my_pos = pal_pkg::CMP_W'(idx);
	assign entry  = entry_q;

	always_ff @(posedge clk) begin
		if (bc.do_ins) begin
			if (my_pos == bc.pos) begin
				entry_q <= bc.value;
			end else if (my_pos > bc.pos) begin
				entry_q <= left;
			end
		end else if (bc.do_del) begin
			if (my_pos >= bc.pos) begin
				entry_q <= right;
			end
		end
	end

	// Only cells below the current length take part in a search.
	assign hit   = (entry_q == bc.value) && (my_pos < bc.count);
	assign rdata = (my_pos == bc.pos) ? entry_q : '0;

endmodule

[rtl/pal_group.sv]
// ---------------------------------------------------------------------------
// pal_group: reducer for one group of cells
// Finds the lowest hit in the group and merges the masked read data.
// ---------------------------------------------------------------------------
module pal_group (
	input  logic [pal_pkg::GROUP-1:0]                     hit,
	input  logic [pal_pkg::GROUP-1:0][pal_pkg::DATA_W-1:0] rdata,
	output pal_pkg::grp_t                                 res
);

	always_comb begin
		res.any_hit = |hit;
		res.first   = '0;
		res.rdata   = '0;
		for (int l = pal_pkg::GROUP - 1; l >= 0; l--) begin
			if (hit[l]) begin
				res.first = pal_pkg::LIDX_W'(l);
			end
			res.rdata = res.rdata | rdata[l];
		end
	end

endmodule

[verif/positional_array_list_unit_tb.sv]
// ---------------------------------------------------------------------------
// positional_array_list_unit_tb: self-checking bench for the array list unit
// Drives a short table of directed commands and then about 1500 random
// commands in grow, shrink and mixed phases. Every result beat is compared
// field by field with a shadow copy of the list kept inside the bench.
// ---------------------------------------------------------------------------
module positional_array_list_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Expected contents of one result beat.
	typedef struct {
		logic signed [31:0] read_value;
		logic [5:0]         found_position;
		pal_pkg::status_t   status;
		logic [6:0]         list_length;
	} list_result_t;

	// One row of the directed table. When has_typed is set, the result typed
	// into the row is what the beat must show. Otherwise the shadow list decides.
	typedef struct {
		pal_pkg::cmd_t      op;
		logic [6:0]         pos;
		logic signed [31:0] value;
		bit                 has_typed;
		list_result_t       typed;
	} directed_row_t;

	localparam int N_DIRECTED = 24;
	localparam int N_PHASES   = 6;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         cmd;
	logic [6:0]         position;
	logic signed [31:0] data_value;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] read_value;
	logic [5:0]         found_position;
	logic [1:0]         status;
	logic [6:0]         list_length;

	// Shadow copy of the list and its length, advanced once per accepted beat.
	logic signed [31:0] shadow_list [pal_pkg::CAPACITY];
	int unsigned        shadow_len;

	// Results still owed by the block, oldest first.
	list_result_t       expected_results [$];
	int unsigned        error_count;

	// Shared controls of the two traffic sides. quiet_mode switches idling
	// off on both sides. long_hold_req asks the receiver for a long stall.
	bit                 quiet_mode;
	bit                 long_hold_req;

	// The directed table. The first rows work on an empty list and their
	// results are plain. Later rows build a short list from the value
	// extremes, read it back, and search it with duplicates present.
	directed_row_t directed_rows [N_DIRECTED] = '{
		'{pal_pkg::CMD_RETRIEVE, 7'd0,   32'sh00000000, 1'b1,
			'{32'sd0, 6'd0, pal_pkg::ST_RANGE, 7'd0}},
		'{pal_pkg::CMD_FIND,     7'd0,   32'sh00000000, 1'b1,
			'{32'sd0, 6'd0, pal_pkg::ST_MISS,  7'd0}},
		'{pal_pkg::CMD_DELETE,   7'd0,   32'sh00000000, 1'b1,
			'{32'sd0, 6'd0, pal_pkg::ST_RANGE, 7'd0}},
		'{pal_pkg::CMD_INSERT,   7'd1,   32'sh00000005, 1'b1,
			'{32'sd0, 6'd0, pal_pkg::ST_RANGE, 7'd0}},
		'{pal_pkg::CMD_INSERT,   7'd127, 32'shFFFFFFFF, 1'b1,
			'{32'sd0, 6'd0, pal_pkg::ST_RANGE, 7'd0}},
		'{pal_pkg::CMD_INSERT,   7'd0,   32'sh7FFFFFFF, 1'b1,
			'{32'sd0, 6'd0, pal_pkg::ST_OK,    7'd1}},
		'{pal_pkg::CMD_INSERT,   7'd0,   32'sh80000000, 1'b1,
			'{32'sd0, 6'd0, pal_pkg::ST_OK,    7'd2}},
		'{pal_pkg::CMD_INSERT,   7'd2,   32'shFFFFFFFF, 1'b1,
			'{32'sd0, 6'd0, pal_pkg::ST_OK,    7'd3}},
		'{pal_pkg::CMD_INSERT,   7'd1,   32'sh00000000, 1'b1,
			'{32'sd0, 6'd0, pal_pkg::ST_OK,    7'd4}},
		'{pal_pkg::CMD_RETRIEVE, 7'd0,   32'sh00000000, 1'b1,
			'{32'sh80000000, 6'd0, pal_pkg::ST_OK, 7'd4}},
		'{pal_pkg::CMD_RETRIEVE, 7'd3,   32'sh00000000, 1'b1,
			'{32'shFFFFFFFF, 6'd0, pal_pkg::ST_OK, 7'd4}},
		'{pal_pkg::CMD_RETRIEVE, 7'd4,   32'sh00000000, 1'b1,
			'{32'sd0, 6'd0, pal_pkg::ST_RANGE, 7'd4}},
		'{pal_pkg::CMD_RETRIEVE, 7'd127, 32'sh7FFFFFFF, 1'b1,
			'{32'sd0, 6'd0, pal_pkg::ST_RANGE, 7'd4}},
		'{pal_pkg::CMD_FIND,     7'd127, 32'sh7FFFFFFF, 1'b0,
			'{32'sd0, 6'd0, pal_pkg::ST_OK,    7'd0}},
		'{pal_pkg::CMD_FIND,     7'd0,   32'sh12345678, 1'b1,
			'{32'sd0, 6'd0, pal_pkg::ST_MISS,  7'd4}},
		'{pal_pkg::CMD_INSERT,   7'd4,   32'sh80000000, 1'b0,
			'{32'sd0, 6'd0, pal_pkg::ST_OK,    7'd0}},
		'{pal_pkg::CMD_FIND,     7'd64,  32'sh80000000, 1'b0,
			'{32'sd0, 6'd0, pal_pkg::ST_OK,    7'd0}},
		'{pal_pkg::CMD_DELETE,   7'd0,   32'sh00000000, 1'b0,
			'{32'sd0, 6'd0, pal_pkg::ST_OK,    7'd0}},
		'{pal_pkg::CMD_FIND,     7'd0,   32'sh80000000, 1'b0,
			'{32'sd0, 6'd0, pal_pkg::ST_OK,    7'd0}},
		'{pal_pkg::CMD_DELETE,   7'd4,   32'sh00000000, 1'b1,
			'{32'sd0, 6'd0, pal_pkg::ST_RANGE, 7'd4}},
		'{pal_pkg::CMD_DELETE,   7'd64,  32'shFFFFFFFF, 1'b1,
			'{32'sd0, 6'd0, pal_pkg::ST_RANGE, 7'd4}},
		'{pal_pkg::CMD_DELETE,   7'd3,   32'sh00000000, 1'b0,
			'{32'sd0, 6'd0, pal_pkg::ST_OK,    7'd0}},
		'{pal_pkg::CMD_RETRIEVE, 7'd2,   32'sh00000000, 1'b0,
			'{32'sd0, 6'd0, pal_pkg::ST_OK,    7'd0}},
		'{pal_pkg::CMD_FIND,     7'd0,   32'sh55555555, 1'b0,
			'{32'sd0, 6'd0, pal_pkg::ST_OK,    7'd0}}
	};

	// Random phases: item count and the percentages of inserts and deletes.
	// Retrieves and finds share what is left. Grow phases run the list into
	// the full case. Shrink phases drain it and hit the empty-list errors.
	int phase_items [N_PHASES] = '{300, 200, 300, 300, 250, 150};
	int phase_ins   [N_PHASES] = '{70,  30,  10,  35,  70,  10};
	int phase_del   [N_PHASES] = '{10,  30,  70,  30,  15,  75};

	positional_array_list_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.position       (position),
		.data_value     (data_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_value     (read_value),
		.found_position (found_position),
		.status         (status),
		.list_length    (list_length)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// This applies one command to the shadow list and returns the beat that
	// the block should produce for it. Inserts check the position before the
	// capacity, so an insert past the end of a full list reports a range error.
	function automatic list_result_t apply_list_cmd(pal_pkg::cmd_t op, logic [6:0] pos,
			logic signed [31:0] value);
		list_result_t res;
		int unsigned  i;
		bit           hit;
		res.read_value     = '0;
		res.found_position = '0;
		res.status         = pal_pkg::ST_OK;
		hit                = 1'b0;
		case (op)
			pal_pkg::CMD_INSERT: begin
				if (pos > shadow_len) begin
					res.status = pal_pkg::ST_RANGE;
				end else if (shadow_len >= pal_pkg::CAPACITY) begin
					res.status = pal_pkg::ST_FULL;
				end else begin
					for (i = shadow_len; i > pos; i--)
						shadow_list[i] = shadow_list[i - 1];
					shadow_list[pos] = value;
					shadow_len++;
				end
			end
			pal_pkg::CMD_DELETE: begin
				if (pos >= shadow_len) begin
					res.status = pal_pkg::ST_RANGE;
				end else begin
					for (i = pos; i + 1 < shadow_len; i++)
						shadow_list[i] = shadow_list[i + 1];
					shadow_len--;
				end
			end
			pal_pkg::CMD_RETRIEVE: begin
				if (pos >= shadow_len)
					res.status = pal_pkg::ST_RANGE;
				else
					res.read_value = shadow_list[pos];
			end
			default: begin
				for (i = 0; i < shadow_len && !hit; i++) begin
					if (shadow_list[i] == value) begin
						res.found_position = i[5:0];
						hit = 1'b1;
					end
				end
				if (!hit)
					res.status = pal_pkg::ST_MISS;
			end
		endcase
		res.list_length = shadow_len[6:0];
		return res;
	endfunction

	// This task offers one command beat, after random idle cycles unless quiet
	// mode is on. It holds the payload until the beat is taken and then books
	// the predicted result. It is entered and left on a rising edge.
	task automatic send_command(pal_pkg::cmd_t op, logic [6:0] pos,
			logic signed [31:0] value, bit has_typed, list_result_t typed);
		list_result_t predicted;
		predicted = apply_list_cmd(op, pos, value);
		// A typed row still advances the shadow list. Only its result is replaced.
		if (has_typed)
			predicted = typed;
		while (!quiet_mode && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		position   <= pos;
		data_value <= value;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(predicted);
	endtask

	task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, field,
				want, got);
			error_count++;
		end
	endtask

	// Reset is asserted at the start of the run and then released once.
	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Receiver side. A long hold is counted here, in cycles, while the sender
	// keeps offering beats, so the pipeline fills up and stalls its input.
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left     = 60;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet_mode && ($urandom_range(99) < 22);
			end
		end
	end

	// Result monitor. Each accepted beat is matched with the oldest expected result.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual status %0d",
					$realtime, status);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("read_value", want.read_value, read_value);
				check_field("found_position", {26'd0, want.found_position},
					{26'd0, found_position});
				check_field("status", {30'd0, want.status}, {30'd0, status});
				check_field("list_length", {25'd0, want.list_length},
					{25'd0, list_length});
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		list_result_t       none;
		pal_pkg::cmd_t      op;
		logic [6:0]         pos;
		logic signed [31:0] value;
		int                 r;
		int                 drain_cycles;
		none          = '{32'sd0, 6'd0, pal_pkg::ST_OK, 7'd0};
		error_count   = 0;
		shadow_len    = 0;
		quiet_mode    = 1'b0;
		long_hold_req = 1'b0;
		in_valid   <= 1'b0;
		cmd        <= pal_pkg::CMD_INSERT;
		position   <= '0;
		data_value <= '0;
		@(posedge arst_n);
		@(posedge clk);

		for (int row = 0; row < N_DIRECTED; row++)
			send_command(directed_rows[row].op, directed_rows[row].pos,
				directed_rows[row].value, directed_rows[row].has_typed,
				directed_rows[row].typed);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// The sender pauses until every result owed so far has come back.
			in_valid <= 1'b0;
			while (expected_results.size() != 0)
				@(posedge clk);
			@(posedge clk);
			quiet_mode = (ph == 1);
			if (ph == 3)
				long_hold_req = 1'b1;

			for (int n = 0; n < phase_items[ph]; n++) begin
				r = $urandom_range(99);
				if (r < phase_ins[ph])
					op = pal_pkg::CMD_INSERT;
				else if (r < phase_ins[ph] + phase_del[ph])
					op = pal_pkg::CMD_DELETE;
				else if ($urandom_range(1) == 0)
					op = pal_pkg::CMD_RETRIEVE;
				else
					op = pal_pkg::CMD_FIND;

				// Most positions are legal for the current length. The rest
				// span the whole field, well past the capacity.
				if ($urandom_range(99) < 15 || op == pal_pkg::CMD_FIND)
					pos = 7'($urandom_range(127));
				else if (op == pal_pkg::CMD_INSERT)
					pos = 7'($urandom_range(shadow_len));
				else if (shadow_len > 0)
					pos = 7'($urandom_range(shadow_len - 1));
				else
					pos = 7'($urandom_range(127));

				// Finds usually look for a value that is in the list. Values
				// are often drawn from a small set, so duplicates are common.
				if (op == pal_pkg::CMD_FIND && shadow_len > 0 &&
						$urandom_range(99) < 60) begin
					value = shadow_list[$urandom_range(shadow_len - 1)];
				end else if ($urandom_range(1) == 0) begin
					case ($urandom_range(7))
						0: value = 32'sh00000000;
						1: value = 32'sh00000001;
						2: value = 32'shFFFFFFFF;
						3: value = 32'sh7FFFFFFF;
						4: value = 32'sh80000000;
						5: value = 32'sh12345678;
						6: value = 32'shA5A5A5A5;
						default: value = 32'sh5A5A5A5A;
					endcase
				end else begin
					value = $urandom;
				end
				send_command(op, pos, value, 1'b0, none);
			end
		end

		// Drain the results, then keep the clock running to catch stray beats.
		in_valid <= 1'b0;
		drain_cycles = 0;
		while (expected_results.size() != 0 && drain_cycles < 10000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: results missing, expected %0d more, actual 0",
				$realtime, expected_results.size());
			error_count++;
		end

		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog. A correct run takes well under a tenth of this time.
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

[positional_array_list_unit.f]
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/pal_group.sv
rtl/positional_array_list_unit.sv
verif/positional_array_list_unit_tb.sv
